// File: rtl/vrd_pkg.sv
// Shared types, constants and helpers for the vertex record decoder.
package vrd_pkg;

    // Record buffer geometry.
    localparam int MaxRecordBytes = 64;
    localparam int PosW           = $clog2(MaxRecordBytes);
    localparam int LimW           = PosW + 1;
    localparam int IdxW           = (LimW > 7) ? LimW : 7;

    // Configuration geometry.
    localparam int StrideW  = 7;
    localparam int FieldW   = 11;
    localparam int NumLanes = 7;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 11;

    // Depth of the queue between the front and the back.
    localparam int QueueDepth = 2;
    localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QCntW      = $clog2(QueueDepth + 1);

    // Register stages of each field lane in the back.
    localparam int LaneStages = 5;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] RegStride     = 3'd0;
    localparam logic [CfgIdxW-1:0] RegXField     = 3'd1;
    localparam logic [CfgIdxW-1:0] RegYField     = 3'd2;
    localparam logic [CfgIdxW-1:0] RegZField     = 3'd3;
    localparam logic [CfgIdxW-1:0] RegRedField   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegGreenField = 3'd5;
    localparam logic [CfgIdxW-1:0] RegBlueField  = 3'd6;
    localparam logic [CfgIdxW-1:0] RegAlphaField = 3'd7;

    // Lane numbers, one lane per decoded field.
    localparam int LaneX     = 0;
    localparam int LaneY     = 1;
    localparam int LaneZ     = 2;
    localparam int LaneRed   = 3;
    localparam int LaneGreen = 4;
    localparam int LaneBlue  = 5;
    localparam int LaneAlpha = 6;

    // Source type codes; anything else decodes as float32.
    localparam logic [3:0] TypeF32 = 4'd0;
    localparam logic [3:0] TypeF64 = 4'd1;
    localparam logic [3:0] TypeU8  = 4'd2;
    localparam logic [3:0] TypeI8  = 4'd3;
    localparam logic [3:0] TypeU16 = 4'd4;
    localparam logic [3:0] TypeI16 = 4'd5;
    localparam logic [3:0] TypeU32 = 4'd6;
    localparam logic [3:0] TypeI32 = 4'd7;

    // Reset values of the configuration registers.
    localparam logic [StrideW-1:0] StrideReset = 7'd12;
    localparam logic [FieldW-1:0]  XReset      = 11'd1024;
    localparam logic [FieldW-1:0]  YReset      = 11'd1028;
    localparam logic [FieldW-1:0]  ZReset      = 11'd1032;
    localparam logic [FieldW-1:0]  ColReset    = 11'd0;

    // Quiet NaN given for an absent coordinate.
    localparam logic [63:0] CoordAbsent = 64'h7FF8_0000_0000_0000;

    // One field of a finished record, as raw little-endian bytes.
    typedef struct packed {
        logic [63:0] raw;
        logic [3:0]  ftype;
        logic        present;
    } t_lane_in;

    typedef t_lane_in [NumLanes-1:0] t_record;

    // Number of bytes that a field of the given type occupies.
    function automatic logic [3:0] field_size(input logic [3:0] ftype);
        logic [3:0] v_size;
        case (ftype)
            TypeF64: v_size = 4'd8;
            TypeU8:  v_size = 4'd1;
            TypeI8:  v_size = 4'd1;
            TypeU16: v_size = 4'd2;
            TypeI16: v_size = 4'd2;
            default: v_size = 4'd4;
        endcase
        return v_size;
    endfunction

endpackage

// File: rtl/binary_vertex_record_decoder.sv
// Channel   Direction  Handshake           Payload
// payload   in         i_valid / o_stall   i_payload_byte
// vertex    out        o_valid / i_stall   o_x_bits o_y_bits o_z_bits o_red o_green
//                                          o_blue o_alpha
// config    in         i_cfg_we            i_cfg_index i_cfg_data
//
// One payload byte is taken per cycle while the record queue has room; a record
// passes through a queue entry, the five register stages of each field lane and the
// output register, and one vertex per cycle can follow while the output is not stalled.
// Reset is synchronous and active low; it clears the byte position, the
// record queue and the pipeline valids and loads the register defaults.
// The input stalls only while the two-entry record queue is full.
module binary_vertex_record_decoder import vrd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_payload_byte,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [63:0]         o_x_bits,
    output logic [63:0]         o_y_bits,
    output logic [63:0]         o_z_bits,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [7:0]          o_alpha,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    logic [StrideW-1:0]              r_stride;
    logic [NumLanes-1:0][FieldW-1:0] r_desc;
    logic                            w_push;
    logic                            w_pop;
    logic                            w_q_empty;
    logic                            w_q_full;
    t_record                         w_rec_in;
    t_record                         w_rec_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride           <= StrideReset;
            r_desc[LaneX]      <= XReset;
            r_desc[LaneY]      <= YReset;
            r_desc[LaneZ]      <= ZReset;
            r_desc[LaneRed]    <= ColReset;
            r_desc[LaneGreen]  <= ColReset;
            r_desc[LaneBlue]   <= ColReset;
            r_desc[LaneAlpha]  <= ColReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegStride:     r_stride          <= i_cfg_data[StrideW-1:0];
                RegXField:     r_desc[LaneX]     <= i_cfg_data[FieldW-1:0];
                RegYField:     r_desc[LaneY]     <= i_cfg_data[FieldW-1:0];
                RegZField:     r_desc[LaneZ]     <= i_cfg_data[FieldW-1:0];
                RegRedField:   r_desc[LaneRed]   <= i_cfg_data[FieldW-1:0];
                RegGreenField: r_desc[LaneGreen] <= i_cfg_data[FieldW-1:0];
                RegBlueField:  r_desc[LaneBlue]  <= i_cfg_data[FieldW-1:0];
                RegAlphaField: r_desc[LaneAlpha] <= i_cfg_data[FieldW-1:0];
                default: ;
            endcase
        end
    end

    vrd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_payload_byte (i_payload_byte),
        .i_stride       (r_stride),
        .i_desc         (r_desc),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_rec          (w_rec_in)
    );

    vrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .i_pop   (w_pop),
        .o_rec   (w_rec_out),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    vrd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_rec     (w_rec_out),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_x_bits  (o_x_bits),
        .o_y_bits  (o_y_bits),
        .o_z_bits  (o_z_bits),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue),
        .o_alpha   (o_alpha)
    );

`ifndef SYNTH
    // A record is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full))
        else $error("record pushed into a full queue");

    // Nothing is popped while the held vertex is stalled.
    a_hold_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !w_pop)
        else $error("queue popped while the output is stalled");

    // The queue is never popped when empty.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("pop from an empty queue");

    // No vertex is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");
`endif

endmodule

// File: rtl/vrd_front.sv
// Front: takes payload bytes, captures the bytes of each field as they pass
// and hands a finished record to the queue.
module vrd_front import vrd_pkg::*; (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_payload_byte,
    input  logic [StrideW-1:0]              i_stride,
    input  logic [NumLanes-1:0][FieldW-1:0] i_desc,
    input  logic                            i_q_full,
    output logic                            o_push,
    output t_record                         o_rec
);

    logic [PosW-1:0] r_pos;
    logic [PosW-1:0] n_pos;
    logic [7:0]      r_cap [NumLanes][8];
    logic [IdxW-1:0] w_lim;
    logic [IdxW-1:0] w_pos;
    logic [IdxW-1:0] w_pos_inc;
    logic            w_accept;
    logic            w_done;

    // A byte is taken whenever the queue has room for a possible record.
    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;

    // Effective stride: zero counts as one, large values saturate.
    always_comb begin
        if (i_stride == '0) begin
            w_lim = IdxW'(1);
        end else if (IdxW'(i_stride) > IdxW'(MaxRecordBytes)) begin
            w_lim = IdxW'(MaxRecordBytes);
        end else begin
            w_lim = IdxW'(i_stride);
        end
    end

    assign w_pos     = IdxW'(r_pos);
    assign w_pos_inc = w_pos + IdxW'(1);
    assign w_done    = (w_pos_inc >= w_lim);
    assign n_pos     = w_done ? '0 : w_pos_inc[PosW-1:0];
    assign o_push    = w_accept && w_done;

    // Byte position within the current record.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_accept) begin
            r_pos <= n_pos;
        end
    end

    // Each field slot keeps the byte that arrives at its own position.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int l = 0; l < NumLanes; l++) begin
                for (int i = 0; i < 8; i++) begin
                    if (w_pos == IdxW'(i_desc[l][5:0]) + IdxW'(i)) begin
                        r_cap[l][i] <= i_payload_byte;
                    end
                end
            end
        end
    end

    // Assemble the finished record, taking the current byte where it belongs
    // and reading bytes past the field or past the stride as zero.
    always_comb begin
        logic [IdxW-1:0] v_idx;
        logic [3:0]      v_size;
        logic [63:0]     v_raw;
        for (int l = 0; l < NumLanes; l++) begin
            v_size = field_size(i_desc[l][9:6]);
            v_raw  = '0;
            for (int i = 0; i < 8; i++) begin
                v_idx = IdxW'(i_desc[l][5:0]) + IdxW'(i);
                if ((4'(i) < v_size) && (v_idx < w_lim)) begin
                    v_raw[8*i +: 8] = (v_idx == w_pos) ? i_payload_byte : r_cap[l][i];
                end
            end
            o_rec[l].raw     = v_raw;
            o_rec[l].ftype   = i_desc[l][9:6];
            o_rec[l].present = i_desc[l][10];
        end
    end

endmodule

// File: rtl/vrd_queue.sv
// Short record queue between the front and the back.
module vrd_queue import vrd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_record i_rec,
    input  logic    i_pop,
    output t_record o_rec,
    output logic    o_empty,
    output logic    o_full
);

    t_record           r_mem [QueueDepth];
    logic [QPtrW-1:0]  r_wr;
    logic [QPtrW-1:0]  r_rd;
    logic [QCntW-1:0]  r_cnt;
    logic [QCntW-1:0]  n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCntW'(QueueDepth));
    assign o_rec   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCntW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - QCntW'(1);
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= (r_wr == QPtrW'(QueueDepth - 1)) ? '0 : r_wr + QPtrW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPtrW'(QueueDepth - 1)) ? '0 : r_rd + QPtrW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule

// File: rtl/vrd_lane.sv
// One field lane of the back: widens the raw field to a float64 pattern and
// works out its normalized colour value over five register stages.
module vrd_lane import vrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_lane_in    i_lane,
    output logic [63:0] o_bits,
    output logic [7:0]  o_colour
);

    // Stage 1 registers.
    logic        r1_pass;
    logic [63:0] r1_bits;
    logic        r1_sign;
    logic [31:0] r1_mag;
    logic [10:0] r1_base;
    logic        r1_coldone;
    logic [7:0]  r1_col;
    // Stage 2 registers.
    logic        r2_pass;
    logic [63:0] r2_bits;
    logic        r2_sign;
    logic [31:0] r2_mag;
    logic [10:0] r2_base;
    logic [4:0]  r2_p;
    logic        r2_coldone;
    logic [7:0]  r2_col;
    // Stage 3 registers.
    logic [63:0] r3_bits;
    logic        r3_coldone;
    logic [7:0]  r3_col;
    // Stage 4 registers.
    logic [63:0] r4_bits;
    logic        r4_done;
    logic [7:0]  r4_col;
    logic [69:0] r4_prod;
    logic [4:0]  r4_lsb;
    // Stage 5 registers.
    logic [63:0] r5_bits;
    logic [7:0]  r5_col;

    logic        n1_pass;
    logic [63:0] n1_bits;
    logic        n1_sign;
    logic [31:0] n1_mag;
    logic [10:0] n1_base;
    logic        n1_coldone;
    logic [7:0]  n1_col;
    logic [4:0]  n2_p;
    logic [63:0] n3_bits;
    logic        n4_done;
    logic [7:0]  n4_col;
    logic [69:0] n4_prod;
    logic [4:0]  n4_lsb;
    logic [7:0]  n5_col;

    // Stage 1: unpack the raw field by type.
    always_comb begin
        logic [7:0]  v_e8;
        logic [22:0] v_m23;
        logic [32:0] v_sval;
        logic [32:0] v_neg;
        logic        v_int;
        logic [24:0] v_y16;
        logic [16:0] v_t16;
        logic [9:0]  v_q16;
        logic [40:0] v_y32;
        logic [32:0] v_t32;
        logic [9:0]  v_q32;
        v_e8       = i_lane.raw[30:23];
        v_m23      = i_lane.raw[22:0];
        v_int      = 1'b1;
        v_sval     = {1'b0, i_lane.raw[31:0]};
        n1_pass    = 1'b1;
        n1_bits    = i_lane.raw;
        n1_sign    = 1'b0;
        n1_mag     = '0;
        n1_base    = 11'd1023;
        n1_coldone = 1'b0;
        n1_col     = 8'hFF;

        // Integer values and their colour rules.
        case (i_lane.ftype)
            TypeU8:  v_sval = {25'd0, i_lane.raw[7:0]};
            TypeI8:  v_sval = {{25{i_lane.raw[7]}}, i_lane.raw[7:0]};
            TypeU16: v_sval = {17'd0, i_lane.raw[15:0]};
            TypeI16: v_sval = {{17{i_lane.raw[15]}}, i_lane.raw[15:0]};
            TypeU32: v_sval = {1'b0, i_lane.raw[31:0]};
            TypeI32: v_sval = {i_lane.raw[31], i_lane.raw[31:0]};
            default: v_int  = 1'b0;
        endcase
        v_neg = '0 - v_sval;

        // Unsigned 16 bit: round(v * 255 / 65535), split around the modulus.
        v_y16 = (25'(i_lane.raw[15:0]) << 9) - (25'(i_lane.raw[15:0]) << 1) + 25'd65535;
        v_t16 = 17'(v_y16[24:16]) + 17'(v_y16[15:0]);
        v_q16 = 10'(v_y16[24:16]) + 10'(v_t16 >= 17'd65535);
        // Unsigned 32 bit: the same with a 32 bit modulus.
        v_y32 = (41'(i_lane.raw[31:0]) << 9) - (41'(i_lane.raw[31:0]) << 1)
              + 41'h0_FFFF_FFFF;
        v_t32 = 33'(v_y32[40:32]) + 33'(v_y32[31:0]);
        v_q32 = 10'(v_y32[40:32]) + 10'(v_t32 >= 33'h0_FFFF_FFFF);

        if (!i_lane.present) begin
            n1_bits    = CoordAbsent;
            n1_coldone = 1'b1;
            n1_col     = 8'hFF;
        end else if (v_int) begin
            n1_sign    = v_sval[32];
            n1_mag     = v_sval[32] ? v_neg[31:0] : v_sval[31:0];
            n1_pass    = (v_sval == '0);
            n1_bits    = '0;
            n1_base    = 11'd1023;
            n1_coldone = 1'b1;
            case (i_lane.ftype)
                TypeU8:  n1_col = i_lane.raw[7:0];
                TypeU16: n1_col = v_q16[8:1];
                TypeU32: n1_col = v_q32[8:1];
                default: begin
                    if (v_sval[32]) begin
                        n1_col = 8'd0;
                    end else if (v_sval == 33'd1 || v_sval >= 33'd255) begin
                        n1_col = 8'hFF;
                    end else begin
                        n1_col = v_sval[7:0];
                    end
                end
            endcase
        end else if (i_lane.ftype != TypeF64) begin
            // float32 widened to float64.
            if (v_e8 == 8'hFF) begin
                n1_bits = {i_lane.raw[31], 11'h7FF, (v_m23 != '0), v_m23[21:0], 29'd0};
                if (v_m23 == '0) begin
                    n1_bits = {i_lane.raw[31], 11'h7FF, 52'd0};
                end
            end else if (v_e8 == 8'd0) begin
                n1_bits = {i_lane.raw[31], 63'd0};
                n1_sign = i_lane.raw[31];
                n1_mag  = {9'd0, v_m23};
                n1_base = 11'd874;
                n1_pass = (v_m23 == '0);
            end else begin
                n1_bits = {i_lane.raw[31], 11'(v_e8) + 11'd896, v_m23, 29'd0};
            end
        end
    end

    // Stage 2: position of the leading one of the magnitude.
    always_comb begin
        n2_p = '0;
        for (int i = 0; i < 32; i++) begin
            if (r1_mag[i]) begin
                n2_p = 5'(i);
            end
        end
    end

    // Stage 3: normalize into a float64 pattern.
    always_comb begin
        logic [52:0] v_frac;
        logic [5:0]  v_sh;
        v_sh   = 6'd52 - 6'(r2_p);
        v_frac = 53'(r2_mag) << v_sh;
        if (r2_pass) begin
            n3_bits = r2_bits;
        end else begin
            n3_bits = {r2_sign, r2_base + 11'(r2_p), v_frac[51:0]};
        end
    end

    // Stage 4: colour of a float value; values in 0..1 form an exact product
    // by 255 that stage 5 rounds.
    always_comb begin
        logic        v_s;
        logic [10:0] v_e;
        logic [51:0] v_f;
        logic [52:0] v_m;
        logic [10:0] v_d;
        logic [3:0]  v_sh;
        logic [61:0] v_v;
        logic [2:0]  v_k;
        logic [52:0] v_int;
        logic [8:0]  v_ip;
        logic        v_half;
        v_s     = r3_bits[63];
        v_e     = r3_bits[62:52];
        v_f     = r3_bits[51:0];
        v_m     = {1'b1, v_f};
        v_d     = v_e - 11'd1014;
        v_sh    = v_d[3:0];
        v_v     = 62'(v_m) << v_sh;
        n4_prod = (70'(v_v) << 8) - 70'(v_v);
        n4_lsb  = n4_prod[7'd60 + 7'(v_sh)] ? 5'd8 + 5'(v_sh) : 5'd7 + 5'(v_sh);
        v_k     = 3'(v_e - 11'd1023);
        v_int   = v_m >> (6'd52 - 6'(v_k));
        v_ip    = v_int[8:0];
        v_half  = v_m[6'd51 - 6'(v_k)];
        n4_done = 1'b1;
        n4_col  = 8'hFF;
        if (r3_coldone) begin
            n4_col = r3_col;
        end else if (v_e == 11'h7FF) begin
            n4_col = 8'hFF;
        end else if (v_s) begin
            n4_col = 8'd0;
        end else if (v_e <= 11'd1013) begin
            n4_col = 8'd0;
        end else if (v_e < 11'd1023 || (v_e == 11'd1023 && v_f == '0)) begin
            n4_done = 1'b0;
        end else if (v_e >= 11'd1031) begin
            n4_col = 8'hFF;
        end else if (v_ip >= 9'd255) begin
            n4_col = 8'hFF;
        end else begin
            n4_col = v_ip[7:0] + 8'(v_half);
        end
    end

    // Stage 5: round the product to float64 precision, then half up.
    always_comb begin
        logic [69:0] v_mask;
        logic        v_halfb;
        logic        v_sticky;
        logic        v_lsbb;
        logic [69:0] v_pt;
        logic [70:0] v_xr;
        v_mask   = (70'(1) << (r4_lsb - 5'd1)) - 70'(1);
        v_halfb  = r4_prod[r4_lsb - 5'd1];
        v_sticky = |(r4_prod & v_mask);
        v_lsbb   = r4_prod[r4_lsb];
        v_pt     = (r4_prod >> r4_lsb) + 70'(v_halfb && (v_sticky || v_lsbb));
        v_xr     = (71'(v_pt) << r4_lsb) + (71'(1) << 60);
        n5_col   = r4_done ? r4_col : v_xr[68:61];
    end

    // Stage registers; the whole lane advances together.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pass    <= n1_pass;
            r1_bits    <= n1_bits;
            r1_sign    <= n1_sign;
            r1_mag     <= n1_mag;
            r1_base    <= n1_base;
            r1_coldone <= n1_coldone;
            r1_col     <= n1_col;
            r2_pass    <= r1_pass;
            r2_bits    <= r1_bits;
            r2_sign    <= r1_sign;
            r2_mag     <= r1_mag;
            r2_base    <= r1_base;
            r2_p       <= n2_p;
            r2_coldone <= r1_coldone;
            r2_col     <= r1_col;
            r3_bits    <= n3_bits;
            r3_coldone <= r2_coldone;
            r3_col     <= r2_col;
            r4_bits    <= r3_bits;
            r4_done    <= n4_done;
            r4_col     <= n4_col;
            r4_prod    <= n4_prod;
            r4_lsb     <= n4_lsb;
            r5_bits    <= r4_bits;
            r5_col     <= n5_col;
        end
    end

    assign o_bits   = r5_bits;
    assign o_colour = r5_col;

endmodule

// File: rtl/vrd_back.sv
// Back: pops records from the queue, runs them through the field lanes and
// holds the finished vertex in the output register.
module vrd_back import vrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_record     i_rec,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_x_bits,
    output logic [63:0] o_y_bits,
    output logic [63:0] o_z_bits,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha
);

    logic [LaneStages-1:0] r_v;
    logic                  r_out_valid;
    logic [63:0]           r_bits [3];
    logic [7:0]            r_col  [4];
    logic [63:0]           w_bits [NumLanes];
    logic [7:0]            w_col  [NumLanes];
    logic                  w_en;

    // The pipeline moves unless a held result is stalled.
    assign w_en  = !(r_out_valid && i_stall);
    assign o_pop = w_en && !i_q_empty;

    for (genvar l = 0; l < NumLanes; l++) begin : g_lane
        vrd_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_lane   (i_rec[l]),
            .o_bits   (w_bits[l]),
            .o_colour (w_col[l])
        );
    end

    // Stage valid bits and the output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v         <= {r_v[LaneStages-2:0], o_pop};
            r_out_valid <= r_v[LaneStages-1];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bits[0] <= w_bits[LaneX];
            r_bits[1] <= w_bits[LaneY];
            r_bits[2] <= w_bits[LaneZ];
            r_col[0]  <= w_col[LaneRed];
            r_col[1]  <= w_col[LaneGreen];
            r_col[2]  <= w_col[LaneBlue];
            r_col[3]  <= w_col[LaneAlpha];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_x_bits = r_bits[0];
    assign o_y_bits = r_bits[1];
    assign o_z_bits = r_bits[2];
    assign o_red    = r_col[0];
    assign o_green  = r_col[1];
    assign o_blue   = r_col[2];
    assign o_alpha  = r_col[3];

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import vrd_pkg::*;

    // One decoded vertex as it leaves the block.
    typedef struct {
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
    } t_vertex;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [7:0]          i_payload_byte = 8'd0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [63:0]         o_x_bits;
    logic [63:0]         o_y_bits;
    logic [63:0]         o_z_bits;
    logic [7:0]          o_red;
    logic [7:0]          o_green;
    logic [7:0]          o_blue;
    logic [7:0]          o_alpha;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = RegStride;
    logic [CfgDataW-1:0] i_cfg_data = 11'd0;

    // Bytes waiting to be sent, and vertices the block still owes us.
    logic [7:0] byte_q[$];
    t_vertex    vertex_q[$];
    int         fail_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    // Shadow of the register file and of the record buffer.
    logic [10:0] shadow_reg[0:7];
    logic [7:0]  shadow_rec[0:MaxRecordBytes-1];
    int          shadow_pos;

    binary_vertex_record_decoder dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int eff_stride();
        int s;
        s = int'(shadow_reg[RegStride][6:0]);
        if (s == 0) s = 1;
        if (s > MaxRecordBytes) s = MaxRecordBytes;
        return s;
    endfunction

    function automatic logic [63:0] fetch_le(int at, int n);
        logic [63:0] v;
        int          idx;
        v = 64'd0;
        for (int i = 0; i < n; i++) begin
            idx = at + i;
            if (idx < eff_stride() && idx < MaxRecordBytes) v[8*i +: 8] = shadow_rec[idx];
        end
        return v;
    endfunction

    function automatic logic [63:0] widen_single(logic [31:0] u);
        logic [63:0] sgn;
        logic [63:0] m;
        logic [63:0] e64;
        sgn = {u[31], 63'd0};
        m = {41'd0, u[22:0]};
        if (u[30:23] == 8'hFF) begin
            if (m != 0) return sgn | (64'h7FF << 52) | (64'd1 << 51) | (m << 29);
            return sgn | (64'h7FF << 52);
        end
        if (u[30:23] == 8'h00) begin
            if (m == 0) return sgn;
            e64 = 64'd897;
            while ((m & 64'h800000) == 0) begin
                m = m << 1;
                e64 = e64 - 64'd1;
            end
            m = m & 64'h7FFFFF;
            return sgn | (e64 << 52) | (m << 29);
        end
        e64 = 64'(u[30:23]) + 64'd896;
        return sgn | (e64 << 52) | (m << 29);
    endfunction

    // Field value as a double bit pattern, by source type.
    function automatic logic [63:0] field_bits(logic [10:0] desc);
        int          off;
        logic [63:0] raw;
        off = int'(desc[5:0]);
        case (desc[9:6])
            TypeF64: return fetch_le(off, 8);
            TypeU8:  return $realtobits(real'(longint'(fetch_le(off, 1))));
            TypeI8:  begin
                raw = fetch_le(off, 1);
                return $realtobits(real'(longint'($signed(raw[7:0]))));
            end
            TypeU16: return $realtobits(real'(longint'(fetch_le(off, 2))));
            TypeI16: begin
                raw = fetch_le(off, 2);
                return $realtobits(real'(longint'($signed(raw[15:0]))));
            end
            TypeU32: return $realtobits(real'(longint'(fetch_le(off, 4))));
            TypeI32: begin
                raw = fetch_le(off, 4);
                return $realtobits(real'(longint'($signed(raw[31:0]))));
            end
            default: return widen_single(32'(fetch_le(off, 4)));
        endcase
    endfunction

    // Round half away from zero for non-negative values below 256.
    function automatic int round_half_up(real x);
        int t;
        t = $rtoi(x);
        if (x - real'(t) >= 0.5) t++;
        return t;
    endfunction

    function automatic logic [7:0] channel_value(logic [10:0] desc);
        logic [63:0] bits;
        real         v;
        real         mx;
        int          r;
        if (!desc[10]) return 8'd255;
        bits = field_bits(desc);
        if (bits[62:52] == 11'h7FF) return 8'd255;
        v = $bitstoreal(bits);
        if (desc[9:6] == TypeU8 || desc[9:6] == TypeU16 || desc[9:6] == TypeU32) begin
            mx = (desc[9:6] == TypeU8) ? 255.0 : (desc[9:6] == TypeU16) ? 65535.0 : 4294967295.0;
            if (v < 0.0) v = 0.0;
            if (v > mx) v = mx;
            if (mx <= 255.0) r = round_half_up(v);
            else r = round_half_up((v * 255.0) / mx);
            if (r > 255) r = 255;
        end else if (v >= 0.0 && v <= 1.0) begin
            r = round_half_up(v * 255.0);
        end else if (v < 0.0) begin
            r = 0;
        end else if (v >= 255.0) begin
            r = 255;
        end else begin
            r = round_half_up(v);
        end
        return r[7:0];
    endfunction

    function automatic logic [63:0] coord_value(logic [10:0] desc);
        if (!desc[10]) return CoordAbsent;
        return field_bits(desc);
    endfunction

    // Buffer one accepted byte and queue the vertex that a full record yields.
    function automatic void absorb_byte(logic [7:0] b);
        t_vertex v;
        if (shadow_pos < MaxRecordBytes) shadow_rec[shadow_pos] = b;
        shadow_pos++;
        if (shadow_pos < eff_stride()) return;
        shadow_pos = 0;
        v.x = coord_value(shadow_reg[RegXField]);
        v.y = coord_value(shadow_reg[RegYField]);
        v.z = coord_value(shadow_reg[RegZField]);
        v.r = channel_value(shadow_reg[RegRedField]);
        v.g = channel_value(shadow_reg[RegGreenField]);
        v.b = channel_value(shadow_reg[RegBlueField]);
        v.a = channel_value(shadow_reg[RegAlphaField]);
        vertex_q.push_back(v);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Sender: a transfer happens at an edge with valid high and stall low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) absorb_byte(i_payload_byte);
            if (!i_valid || !o_stall) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_payload_byte <= byte_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall, and a field by field check of each vertex.
    always @(posedge i_clk) begin
        t_vertex w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (vertex_q.size() == 0) begin
                    report_mismatch("unexpected vertex x", o_x_bits, 64'd0);
                end else begin
                    w = vertex_q.pop_front();
                    if (o_x_bits !== w.x) report_mismatch("x", o_x_bits, w.x);
                    if (o_y_bits !== w.y) report_mismatch("y", o_y_bits, w.y);
                    if (o_z_bits !== w.z) report_mismatch("z", o_z_bits, w.z);
                    if (o_red !== w.r) report_mismatch("red", 64'(o_red), 64'(w.r));
                    if (o_green !== w.g) report_mismatch("green", 64'(o_green), 64'(w.g));
                    if (o_blue !== w.b) report_mismatch("blue", 64'(o_blue), 64'(w.b));
                    if (o_alpha !== w.a) report_mismatch("alpha", 64'(o_alpha), 64'(w.a));
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Wait until every byte is sent and every vertex seen, then let the pipe drain.
    task automatic wait_quiet();
        do @(negedge i_clk); while (byte_q.size() != 0 || i_valid || vertex_q.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [10:0] data);
        wait_quiet();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        shadow_reg[idx] = (idx == RegStride) ? {4'd0, data[6:0]} : data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Payload byte biased toward float edge patterns.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h3F;
            3: return 8'h80;
            4: return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [10:0] pick_desc(int stride);
        logic [10:0] d;
        d = 11'($urandom_range(2047));
        if ($urandom_range(3) != 0) begin
            d[10] = 1'b1;
            d[5:0] = 6'($urandom_range((stride > 64 ? 64 : stride) - 1));
            if ($urandom_range(3) != 0) d[9:6] = 4'($urandom_range(8));
        end
        return d;
    endfunction

    task automatic random_setting();
        int stride;
        int n_rec;
        int n_part;
        case ($urandom_range(9))
            0: stride = 127;
            1: stride = 0;
            2: stride = 1;
            3: stride = 64;
            default: stride = $urandom_range(3, 24);
        endcase
        write_reg(RegStride, 11'(stride));
        for (int r = 1; r < 8; r++) write_reg(CfgIdxW'(r), pick_desc(eff_stride()));
        n_rec = 80 / eff_stride();
        if (n_rec < 1) n_rec = 1;
        for (int i = 0; i < n_rec * eff_stride(); i++) byte_q.push_back(pick_byte());
        // Sometimes leave a record half filled, then close it by lowering the stride.
        if ($urandom_range(3) == 0) begin
            n_part = $urandom_range(1, 5);
            for (int i = 0; i < n_part; i++) byte_q.push_back(pick_byte());
            write_reg(RegStride, 11'd1);
            byte_q.push_back(pick_byte());
        end
    endtask

    initial begin
        logic [31:0] one_f;
        shadow_reg[RegStride] = 11'(StrideReset);
        shadow_reg[RegXField] = XReset;
        shadow_reg[RegYField] = YReset;
        shadow_reg[RegZField] = ZReset;
        for (int r = RegRedField; r <= RegAlphaField; r++) shadow_reg[r] = ColReset;
        for (int i = 0; i < MaxRecordBytes; i++) shadow_rec[i] = 8'd0;
        shadow_pos = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default layout: three float32 values, 1.0, negative infinity and a NaN.
        one_f = 32'h3F80_0000;
        for (int i = 0; i < 4; i++) byte_q.push_back(one_f[8*i +: 8]);
        one_f = 32'hFF80_0000;
        for (int i = 0; i < 4; i++) byte_q.push_back(one_f[8*i +: 8]);
        one_f = 32'h7F80_1234;
        for (int i = 0; i < 4; i++) byte_q.push_back(one_f[8*i +: 8]);

        // Stride one, u8, i8 and float32 colours, absent fields, and a field past the record.
        write_reg(RegStride, 11'd1);
        write_reg(RegXField, 11'd0);
        write_reg(RegYField, {1'b1, TypeI8, 6'd0});
        write_reg(RegZField, {1'b1, TypeF64, 6'd63});
        write_reg(RegRedField, {1'b1, TypeU8, 6'd0});
        write_reg(RegGreenField, {1'b1, TypeI8, 6'd0});
        write_reg(RegBlueField, {1'b1, 4'd15, 6'd0});
        write_reg(RegAlphaField, 11'd0);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h80);
        byte_q.push_back(8'h7F);

        // Stride zero behaves as one.
        write_reg(RegStride, 11'd0);
        byte_q.push_back(8'h01);
        byte_q.push_back(8'hFE);

        // Stride lowered while a record is half received.
        write_reg(RegStride, 11'd8);
        write_reg(RegRedField, {1'b1, TypeU16, 6'd0});
        write_reg(RegGreenField, {1'b1, TypeU32, 6'd2});
        write_reg(RegAlphaField, {1'b1, TypeI16, 6'd1});
        for (int i = 0; i < 5; i++) byte_q.push_back(pick_byte());
        write_reg(RegStride, 11'd4);
        byte_q.push_back(8'hFF);

        // Random settings under three idling patterns.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 28 : (mode == 1) ? 81 : 0;
            recv_stall_pct = (mode == 0) ? 81 : (mode == 1) ? 28 : 0;
            for (int k = 0; k < 4; k++) random_setting();
        end

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
